[rtl/core/video_memory_access_unit_assert.svh]
// ----------------------------------------------------------------------------
// video memory access unit assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef VIDEO_MEMORY_ACCESS_UNIT_ASSERT_SVH
`define VIDEO_MEMORY_ACCESS_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define VMAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define VMAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vmau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmau_pkg
// shared types and constants of the video memory access unit
// ----------------------------------------------------------------------------
package vmau_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned MODE_W    = 3;

  // all stores are kept as 32-bit words with two halfword lanes
  localparam int unsigned VRAM_WORDS = 24576;
  localparam int unsigned VRAM_AW    = 15;
  localparam int unsigned TAB_WORDS  = 256;
  localparam int unsigned TAB_AW     = 8;

  // mode limits for the bitmap window and the object area
  localparam logic [MODE_W-1:0] BITMAP_MODE_FIRST   = 3'd3;
  localparam logic [MODE_W-1:0] OBJ_TILE_MODE_LAST  = 3'd2;
  localparam logic [MODE_W-1:0] OBJ_BMAP_MODE_LAST  = 3'd5;
  localparam logic [2:0]        BITMAP_WINDOW_TOP   = 3'b110;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REGION_VRAM = 2'd0,
    REGION_PAL  = 2'd1,
    REGION_OAM  = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_t;

  typedef struct packed {
    logic    zero;
    region_t region;
    size_t   size;
    logic    hsel;
    logic    bsel;
  } rd_meta_t;

  typedef struct packed {
    logic                vram_we;
    logic                pal_we;
    logic                oam_we;
    logic                vram_re;
    logic                pal_re;
    logic                oam_re;
    logic [1:0]          hen;
    logic [VRAM_AW-1:0]  vram_idx;
    logic [TAB_AW-1:0]   tab_idx;
    logic [DATA_W-1:0]   wdata;
    rd_meta_t            meta;
  } mem_req_t;

endpackage
`default_nettype wire

[rtl/core/vmau_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmau_decode
// turns one access item into store selects, lane enables and read info
// ----------------------------------------------------------------------------
module vmau_decode (
  input  wire logic                          action,
  input  wire logic [1:0]                    region,
  input  wire logic [1:0]                    access_size,
  input  wire logic [vmau_pkg::ADDR_W-1:0]   address,
  input  wire logic [vmau_pkg::DATA_W-1:0]   write_data,
  input  wire logic [vmau_pkg::MODE_W-1:0]   bg_mode,
  output vmau_pkg::mem_req_t                 req
);

  logic                         is_write;
  logic                         blocked;
  logic                         obj_ignore;
  logic [vmau_pkg::ADDR_W-1:0]  vmap;
  vmau_pkg::size_t              size;

  always_comb begin
    size     = vmau_pkg::size_t'(access_size);
    is_write = (vmau_pkg::action_t'(action) == vmau_pkg::ACT_WRITE);

    // upper 32 KiB mirror: bit 15 drops out when bit 16 is set
    vmap = {address[16], address[15] & ~address[16], address[14:0]};

    blocked = (bg_mode >= vmau_pkg::BITMAP_MODE_FIRST) &&
              (address[16:14] == vmau_pkg::BITMAP_WINDOW_TOP);

    obj_ignore = (size == vmau_pkg::SIZE_BYTE) && vmap[16] &&
                 ((bg_mode <= vmau_pkg::OBJ_TILE_MODE_LAST) ||
                  ((bg_mode <= vmau_pkg::OBJ_BMAP_MODE_LAST) && vmap[14]));
  end

  always_comb begin
    req          = '0;
    req.vram_idx = vmap[16:2];
    req.tab_idx  = address[9:2];

    case (vmau_pkg::region_t'(region))
      vmau_pkg::REGION_VRAM: begin
        req.vram_we = is_write && !blocked && !obj_ignore;
        req.vram_re = !is_write && !blocked;
      end
      vmau_pkg::REGION_PAL: begin
        req.pal_we = is_write;
        req.pal_re = !is_write;
      end
      vmau_pkg::REGION_OAM: begin
        req.oam_we = is_write && (size != vmau_pkg::SIZE_BYTE);
        req.oam_re = !is_write;
      end
      default: begin
        req.vram_we = 1'b0;
      end
    endcase

    // byte and halfword data is replicated so the lane enable picks the spot
    case (size)
      vmau_pkg::SIZE_BYTE: begin
        req.hen   = address[1] ? 2'b10 : 2'b01;
        req.wdata = {4{write_data[7:0]}};
      end
      vmau_pkg::SIZE_HALF: begin
        req.hen   = address[1] ? 2'b10 : 2'b01;
        req.wdata = {2{write_data[15:0]}};
      end
      default: begin
        req.hen   = 2'b11;
        req.wdata = write_data;
      end
    endcase

    req.meta.zero   = !(req.vram_re || req.pal_re || req.oam_re);
    req.meta.region = vmau_pkg::region_t'(region);
    req.meta.size   = size;
    req.meta.hsel   = address[1];
    req.meta.bsel   = address[0];
  end

endmodule
`default_nettype wire

[rtl/core/vmau_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmau_ram
// single-port word memory with halfword write enables, registered read
// ----------------------------------------------------------------------------
module vmau_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic                         re,
  input  wire logic [1:0]                   hen,
  input  wire logic [$clog2(DEPTH)-1:0]     addr,
  input  wire logic [vmau_pkg::DATA_W-1:0]  wdata,
  output      logic [vmau_pkg::DATA_W-1:0]  rdata
);

  logic [vmau_pkg::DATA_W-1:0] mem [DEPTH];
  logic [vmau_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we && hen[0]) begin
      mem[addr][15:0] <= wdata[15:0];
    end
    if (we && hen[1]) begin
      mem[addr][31:16] <= wdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/core/video_memory_access_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_memory_access_unit
// processor-side access port to video, palette and object attribute RAM
// ----------------------------------------------------------------------------
// usage:
// - in_* carries one access item (read or write, region, size, address,
//   write data); it is taken when in_valid is high and in_stall is low
// - a read gives one item on out_* in the cycle after it is accepted; a write
//   gives none and is done at its accept edge
// - each item is a single access to one memory port, byte, halfword or
//   word, so one item per cycle is sustained while out_stall stays low
// - a write followed at once by a read of the same word sees the new data,
//   since the read samples the memory after the write has landed
// - while a read result waits with out_stall high, in_stall is raised and
//   the result is held unchanged
// - cfg_wr_en writes bg_mode at once; it should only change while idle
// - reset clears bg_mode to zero and drops any pending result; memory
//   contents are not cleared and read back undefined until written
// ----------------------------------------------------------------------------
module video_memory_access_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [vmau_pkg::MODE_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_action,
  input  wire logic [1:0]                    in_region,
  input  wire logic [1:0]                    in_access_size,
  input  wire logic [vmau_pkg::ADDR_W-1:0]   in_address,
  input  wire logic [vmau_pkg::DATA_W-1:0]   in_write_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [vmau_pkg::DATA_W-1:0]   out_read_data
);

  logic [vmau_pkg::MODE_W-1:0]  bg_mode_r;
  logic                         pend_r;
  logic                         pend_nxt;
  vmau_pkg::rd_meta_t           meta_r;
  vmau_pkg::mem_req_t           req;
  logic                         in_acc;
  logic                         rd_acc;
  logic [vmau_pkg::DATA_W-1:0]  vram_rd;
  logic [vmau_pkg::DATA_W-1:0]  pal_rd;
  logic [vmau_pkg::DATA_W-1:0]  oam_rd;
  logic [vmau_pkg::DATA_W-1:0]  word_sel;
  logic [15:0]                  half_sel;

  vmau_decode u_decode (
    .action      (in_action),
    .region      (in_region),
    .access_size (in_access_size),
    .address     (in_address),
    .write_data  (in_write_data),
    .bg_mode     (bg_mode_r),
    .req         (req)
  );

  vmau_ram #(.DEPTH(vmau_pkg::VRAM_WORDS)) u_vram (
    .clk   (clk),
    .we    (in_acc && req.vram_we),
    .re    (in_acc && req.vram_re),
    .hen   (req.hen),
    .addr  (req.vram_idx),
    .wdata (req.wdata),
    .rdata (vram_rd)
  );

  vmau_ram #(.DEPTH(vmau_pkg::TAB_WORDS)) u_pal (
    .clk   (clk),
    .we    (in_acc && req.pal_we),
    .re    (in_acc && req.pal_re),
    .hen   (req.hen),
    .addr  (req.tab_idx),
    .wdata (req.wdata),
    .rdata (pal_rd)
  );

  vmau_ram #(.DEPTH(vmau_pkg::TAB_WORDS)) u_oam (
    .clk   (clk),
    .we    (in_acc && req.oam_we),
    .re    (in_acc && req.oam_re),
    .hen   (req.hen),
    .addr  (req.tab_idx),
    .wdata (req.wdata),
    .rdata (oam_rd)
  );

  assign in_stall  = pend_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign rd_acc    = in_acc && (vmau_pkg::action_t'(in_action) == vmau_pkg::ACT_READ);
  assign out_valid = pend_r;

  always_comb begin
    pend_nxt = pend_r;
    if (rd_acc) begin
      pend_nxt = 1'b1;
    end else if (pend_r && !out_stall) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_mode_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_wr_en) begin
        bg_mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      meta_r <= req.meta;
    end
  end

  // pick the store, then narrow to the access size
  always_comb begin
    case (meta_r.region)
      vmau_pkg::REGION_VRAM: word_sel = vram_rd;
      vmau_pkg::REGION_PAL:  word_sel = pal_rd;
      vmau_pkg::REGION_OAM:  word_sel = oam_rd;
      default:               word_sel = '0;
    endcase
    if (meta_r.zero) begin
      word_sel = '0;
    end
    half_sel = meta_r.hsel ? word_sel[31:16] : word_sel[15:0];
    case (meta_r.size)
      vmau_pkg::SIZE_BYTE: begin
        out_read_data = {24'd0, meta_r.bsel ? half_sel[15:8] : half_sel[7:0]};
      end
      vmau_pkg::SIZE_HALF: begin
        out_read_data = {16'd0, half_sel};
      end
      default: begin
        out_read_data = word_sel;
      end
    endcase
  end

`include "video_memory_access_unit_assert.svh"

  `VMAU_ASSERT_NEXT(a_read_makes_result, rd_acc, pend_r, "read item left no result")
  `VMAU_ASSERT_NEXT(a_write_no_result,
    in_acc && (vmau_pkg::action_t'(in_action) == vmau_pkg::ACT_WRITE), !pend_r,
    "write item produced a result")
  `VMAU_ASSERT_NEXT(a_stalled_result_held, pend_r && out_stall,
    pend_r && $stable(out_read_data), "stalled result changed or dropped")
  `VMAU_ASSERT_SAME(a_blocked_reads_zero, pend_r && meta_r.zero, out_read_data == '0,
    "blocked read returned nonzero data")
  `VMAU_ASSERT_SAME(a_byte_read_masked, pend_r && (meta_r.size == vmau_pkg::SIZE_BYTE),
    out_read_data[31:8] == 24'd0, "byte read not masked")

endmodule
`default_nettype wire
